FILE: rtl/cpd_pkg.sv
// ----------------------------------------------------------------------------
// cpd_pkg: shared types and constants
// Field widths, the default buffer and dominance settings, and the item
// record passed from the input stage to the peak tracker.
// ----------------------------------------------------------------------------
package cpd_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int METRIC_W      = 32;
    localparam int RUN_W         = 16;
    localparam int POS_W         = 7;
    localparam int ALIGN_W       = RUN_W + 1;
    localparam int IN_DATA_W     = 2 * SAMPLE_W + 3 * METRIC_W;
    localparam int OUT_DATA_W    = RUN_W + 2 * SAMPLE_W + POS_W + ALIGN_W;
    localparam int OUT_USER_W    = 1;

    localparam int BUFFER_LEN_DEF = 80;

    localparam logic [RUN_W-1:0] DOMINANCE_RESET = RUN_W'(16);
    localparam logic [RUN_W-1:0] RUN_MAX         = {RUN_W{1'b1}};

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] real_part;
        logic signed [SAMPLE_W-1:0] imag_part;
        logic [METRIC_W-1:0]        metric;
        logic                       high;
    } cpd_item_t;

endpackage

FILE: rtl/cpd_input_stage.sv
// ----------------------------------------------------------------------------
// cpd_input_stage: input register and threshold test
// Captures one item per cycle while the tracker keeps taking items, and
// reduces numerator/denominator to the sample's high flag.
// ----------------------------------------------------------------------------
module cpd_input_stage
    import cpd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [IN_DATA_W-1:0]   in_data,
    output logic                   item_valid,
    input  logic                   item_ready,
    output cpd_item_t              item
);

    logic                valid_reg;
    logic                valid_next;
    cpd_item_t           item_reg;
    cpd_item_t           item_next;
    logic [METRIC_W-1:0] numer;
    logic [METRIC_W-1:0] scaled;
    logic                accept;

    assign in_ready = !valid_reg || item_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        numer  = in_data[2*SAMPLE_W+METRIC_W +: METRIC_W];
        scaled = in_data[2*SAMPLE_W+2*METRIC_W +: METRIC_W] >> 2;
        item_next.real_part = in_data[0 +: SAMPLE_W];
        item_next.imag_part = in_data[SAMPLE_W +: SAMPLE_W];
        item_next.metric    = in_data[2*SAMPLE_W +: METRIC_W];
        item_next.high      = (scaled != '0) && (numer >= scaled);
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (item_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // hold payload until the tracker takes it
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: rtl/cpd_tracker.sv
// ----------------------------------------------------------------------------
// cpd_tracker: running maximum, dominance run and result register
// Updates the peak state once per item and registers the result.
// ----------------------------------------------------------------------------
module cpd_tracker
    import cpd_pkg::*;
#(
    parameter int BUFFER_LEN = BUFFER_LEN_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [RUN_W-1:0]      cfg_data,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  cpd_item_t             item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_DATA_W-1:0] out_data,
    output logic [OUT_USER_W-1:0] out_user,
    output logic                  out_last
);

    localparam logic [POS_W:0] BUF_LEN_W = (POS_W+1)'(BUFFER_LEN);

    logic [RUN_W-1:0]      dominance_reg;
    logic [METRIC_W-1:0]   best_metric_reg, best_metric_next;
    logic [RUN_W-1:0]      run_count_reg, run_count_next;
    logic                  best_high_reg, best_high_next;
    logic [POS_W-1:0]      best_pos_reg, best_pos_next;
    logic [POS_W-1:0]      sample_pos_reg, sample_pos_next;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic                  peak_reg, peak_next;
    logic                  last_reg, last_next;
    logic                  advance;
    logic                  take;
    logic [POS_W:0]        pos_inc;
    logic [RUN_W-1:0]      index;
    logic [ALIGN_W-1:0]    aligned;

    assign item_ready = !out_valid_reg || out_ready;
    assign advance    = item_valid && item_ready;
    assign take       = item.metric >= best_metric_reg;

    always_comb
    begin
        best_metric_next = take ? item.metric    : best_metric_reg;
        best_high_next   = take ? item.high      : best_high_reg;
        best_pos_next    = take ? sample_pos_reg : best_pos_reg;
        if (take)
        begin
            run_count_next = '0;
        end
        else if (run_count_reg != RUN_MAX)
        begin
            run_count_next = run_count_reg + RUN_W'(1);
        end
        else
        begin
            run_count_next = run_count_reg;
        end

        peak_next = best_high_next && (run_count_next >= dominance_reg);
        index     = best_high_next ? run_count_next : '0;
        aligned   = peak_next ? ({1'b0, run_count_next} + ALIGN_W'(1)) : '0;

        pos_inc         = {1'b0, sample_pos_reg} + (POS_W+1)'(1);
        last_next       = pos_inc >= BUF_LEN_W;
        sample_pos_next = last_next ? '0 : pos_inc[POS_W-1:0];

        out_data_next = {aligned, best_pos_next, item.imag_part, item.real_part, index};

        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dominance_reg   <= DOMINANCE_RESET;
            best_metric_reg <= '0;
            run_count_reg   <= '0;
            best_high_reg   <= 1'b0;
            best_pos_reg    <= '0;
            sample_pos_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                dominance_reg <= cfg_data;
            end
            if (advance)
            begin
                best_metric_reg <= best_metric_next;
                run_count_reg   <= run_count_next;
                best_high_reg   <= best_high_next;
                best_pos_reg    <= best_pos_next;
                sample_pos_reg  <= sample_pos_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
            peak_reg     <= peak_next;
            last_reg     <= last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_user  = peak_reg;
    assign out_last  = last_reg;

    // a registered peak always carries a nonzero aligned count
    a_peak_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && peak_reg |-> out_data_reg[OUT_DATA_W-1 -: ALIGN_W] != '0)
        else $error("peak without aligned count");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, sample_pos_reg} < BUF_LEN_W)
        else $error("sample position beyond buffer");

    a_take_restart: assert property (@(posedge clk) disable iff (!rst_n)
        advance && take |=> run_count_reg == '0)
        else $error("run not restarted on new maximum");

    a_run_grow: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !take |=> run_count_reg >= $past(run_count_reg))
        else $error("run shrank without new maximum");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(best_metric_reg) && $stable(sample_pos_reg))
        else $error("state moved without an item");

endmodule

FILE: rtl/correlation_peak_detector.sv
// ----------------------------------------------------------------------------
// correlation_peak_detector: preamble correlation peak detection
// Tracks the running metric maximum over a sample stream and flags a peak
// once a high maximum has dominated for the configured run length.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   sample, metric, num, den
// m_axis    out        m_axis_tvalid/m_axis_tready   lookback data, peak info
// cfg       in         cfg_valid/cfg_ready           dominance_length
//
// One item per cycle sustained while m_axis is ready; an item's result passes
// through the input register, then the result register, before it is
// presented on m_axis.
// The metric compare and run update are combinational on the tracker state.
// rst_n clears all tracking state and sets dominance_length to 16.
// A stalled m_axis holds its result; s_axis keeps accepting until the input
// register is also full.
// cfg_ready is always high; write dominance_length only while idle.
// ----------------------------------------------------------------------------
module correlation_peak_detector
    import cpd_pkg::*;
#(
    parameter int BUFFER_LEN = BUFFER_LEN_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // cfg_data: dominance_length
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [RUN_W-1:0]      cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // s_axis_tdata: sample_real[15:0], sample_imag[31:16], metric[63:32],
    //               numerator[95:64], denominator[127:96]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // m_axis_tdata: lookback_index[15:0], lookback_real[31:16],
    //               lookback_imag[47:32], peak_position[54:48],
    //               aligned_count[71:55]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // m_axis_tuser: peak_found[0]
    output logic [OUT_USER_W-1:0] m_axis_tuser,
    // m_axis_tlast: buffer_end
    output logic                  m_axis_tlast
);

    cpd_item_t item;
    logic      item_valid;
    logic      item_ready;

    // register writes never stall
    assign cfg_ready = 1'b1;

    // capture the item and reduce the threshold test to one flag
    cpd_input_stage u_input (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_data    (s_axis_tdata),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    // update maximum, run and buffer position; register the result
    cpd_tracker #(
        .BUFFER_LEN (BUFFER_LEN)
    ) u_tracker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata),
        .out_user   (m_axis_tuser),
        .out_last   (m_axis_tlast)
    );

endmodule
